[hw/rtl/int8_matrix_gain_macros.svh]
// Assertion macros shared by the int8_matrix_gain checker.
// No dependencies; included by the checker file.
`ifndef INT8_MATRIX_GAIN_MACROS_SVH
`define INT8_MATRIX_GAIN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("int8_matrix_gain: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("int8_matrix_gain: next-cycle check failed");

// Next-cycle implication that also holds during reset.
`define MG_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("int8_matrix_gain: reset check failed");

`endif

[hw/rtl/mg_pkg.sv]
// Shared types, constants and functions of the int8_matrix_gain block.
// No dependencies; used by mg_cfg, mg_row_ram, mg_engine and int8_matrix_gain.
`default_nettype none

package mg_pkg;

    localparam int DATA_W     = 8;
    localparam int MAX_DIM    = 4;
    localparam int ROW_W      = 2;
    localparam int DIM_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_A   = 3'd0,
        REG_GAIN_B   = 3'd1,
        REG_OUT_ROWS = 3'd2,
        REG_IN_ROWS  = 3'd3,
        REG_SCALAR   = 3'd4
    } cfg_reg_t;

    // Configuration as seen by the engine, dimensions already clamped to 1..MAX_DIM.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] gain_a;
        logic [CFG_DATA_W-1:0] gain_b;
        logic [DIM_W-1:0]      nout;
        logic [DIM_W-1:0]      nin;
        logic                  scalar;
    } cfg_t;

    // Clamp a raw dimension: zero counts as one, values above MAX_DIM saturate.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Gain entry (r,c): rows 0-1 in gain_a, rows 2-3 in gain_b, byte (r mod 2)*4+c.
    function automatic logic [DATA_W-1:0] gain_entry(
        input logic [CFG_DATA_W-1:0] ga,
        input logic [CFG_DATA_W-1:0] gb,
        input logic [ROW_W-1:0]      r,
        input logic [ROW_W-1:0]      c
    );
        logic [CFG_DATA_W-1:0] sel;
        logic [2:0]            byte_idx;
        sel      = r[1] ? gb : ga;
        byte_idx = {r[0], c};
        return sel[{byte_idx, 3'b000} +: DATA_W];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/mg_cfg.sv]
// Configuration register file of the int8_matrix_gain block.
// Depends on mg_pkg for register indexes and the cfg_t struct.
`default_nettype none

module mg_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mg_pkg::CFG_DATA_W-1:0] cfg_data,
    output mg_pkg::cfg_t                       cfg
);

    logic [mg_pkg::CFG_DATA_W-1:0] gain_a_reg;
    logic [mg_pkg::CFG_DATA_W-1:0] gain_b_reg;
    logic [mg_pkg::DIM_W-1:0]      out_rows_reg;
    logic [mg_pkg::DIM_W-1:0]      in_rows_reg;
    logic                          scalar_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_a_reg   <= '0;
            gain_b_reg   <= '0;
            out_rows_reg <= mg_pkg::DIM_W'(1);
            in_rows_reg  <= mg_pkg::DIM_W'(1);
            scalar_reg   <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mg_pkg::REG_GAIN_A:   gain_a_reg   <= cfg_data;
                mg_pkg::REG_GAIN_B:   gain_b_reg   <= cfg_data;
                mg_pkg::REG_OUT_ROWS: out_rows_reg <= cfg_data[mg_pkg::DIM_W-1:0];
                mg_pkg::REG_IN_ROWS:  in_rows_reg  <= cfg_data[mg_pkg::DIM_W-1:0];
                mg_pkg::REG_SCALAR:   scalar_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Present the clamped view to the engine.
    always_comb begin
        cfg.gain_a = gain_a_reg;
        cfg.gain_b = gain_b_reg;
        cfg.nout   = mg_pkg::clamp_dim(out_rows_reg);
        cfg.nin    = mg_pkg::clamp_dim(in_rows_reg);
        cfg.scalar = scalar_reg;
    end

endmodule

`default_nettype wire

[hw/rtl/mg_row_ram.sv]
// Row accumulator memory: four 8-bit entries, one write and one registered read port.
// Depends on mg_pkg for widths; per-entry valid bits make unwritten entries read as zero.
`default_nettype none

module mg_row_ram (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      re,
    input  wire logic [mg_pkg::ROW_W-1:0]  raddr,
    input  wire logic                      we,
    input  wire logic [mg_pkg::ROW_W-1:0]  waddr,
    input  wire logic [mg_pkg::DATA_W-1:0] wdata,
    output logic      [mg_pkg::DATA_W-1:0] rdata
);

    logic [mg_pkg::DATA_W-1:0]  mem [mg_pkg::MAX_DIM];
    logic [mg_pkg::MAX_DIM-1:0] valid_reg;
    logic [mg_pkg::DATA_W-1:0]  rdata_reg;
    logic                       rvalid_reg;

    // Storage array, written and read synchronously.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    // Valid bits: cleared by reset, set on the first write of each entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re) begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    // An entry never written reads as its reset value of zero.
    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

[hw/rtl/mg_engine.sv]
// Multiply-accumulate sequencer: in matrix mode reads a row sum, adds one product, writes it back;
// scalar mode skips the row memory. Depends on mg_pkg and instantiates mg_row_ram; holds the result output register.
`default_nettype none

module mg_engine (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire mg_pkg::cfg_t              cfg,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [mg_pkg::DATA_W-1:0] s_sample,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [mg_pkg::DATA_W-1:0] m_value,
    output logic                           m_last
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_CALC = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [mg_pkg::DATA_W-1:0]   sample_reg;
    logic [mg_pkg::ROW_W-1:0]    col_reg;
    logic [mg_pkg::ROW_W-1:0]    row_reg;
    logic                        scalar_reg;
    logic                        emit_reg;
    logic [mg_pkg::ROW_W-1:0]    elem_idx_reg;
    logic                        out_valid_reg;
    logic [mg_pkg::DATA_W-1:0]   out_value_reg;
    logic                        out_last_reg;

    logic                        accept;
    logic                        col_done;
    logic [mg_pkg::DATA_W-1:0]   gain_sel;
    logic signed [2*mg_pkg::DATA_W-1:0] prod;
    logic [mg_pkg::DATA_W-1:0]   prod8;
    logic [mg_pkg::DATA_W-1:0]   ram_rdata;
    logic [mg_pkg::DATA_W-1:0]   new_sum;
    logic                        last_row;
    logic                        out_free;
    logic                        proceed;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // The sample closes its column when its index reaches in_rows-1 or beyond.
    assign col_done = ({1'b0, elem_idx_reg} + mg_pkg::DIM_W'(1)) >= cfg.nin;

    // One shared multiplier, then the wrapped add into the row sum.
    assign gain_sel = mg_pkg::gain_entry(cfg.gain_a, cfg.gain_b, row_reg, col_reg);
    assign prod     = $signed(gain_sel) * $signed(sample_reg);
    assign prod8    = prod[mg_pkg::DATA_W-1:0];
    assign new_sum  = (col_reg == '0) ? prod8 : ram_rdata + prod8;

    assign last_row = scalar_reg || ({1'b0, row_reg} == (cfg.nout - mg_pkg::DIM_W'(1)));
    assign out_free = !out_valid_reg || m_tready;
    assign proceed  = (state_reg == ST_CALC) && (!emit_reg || out_free);

    mg_row_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .re      (state_reg == ST_READ),
        .raddr   (row_reg),
        .we      (proceed && !scalar_reg),
        .waddr   (row_reg),
        .wdata   (new_sum),
        .rdata   (ram_rdata)
    );

    // Sequencer: ST_READ then ST_CALC per row; scalar mode goes straight to ST_CALC.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = cfg.scalar ? ST_CALC : ST_READ;
                end
            end
            ST_READ: state_next = ST_CALC;
            ST_CALC: begin
                if (proceed) begin
                    state_next = last_row ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            elem_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (proceed && last_row && !scalar_reg) begin
                elem_idx_reg <= emit_reg ? '0 : col_reg + mg_pkg::ROW_W'(1);
            end
            if (proceed && emit_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item context and result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
            col_reg    <= cfg.scalar ? '0 : elem_idx_reg;
            row_reg    <= '0;
            scalar_reg <= cfg.scalar;
            emit_reg   <= cfg.scalar || col_done;
        end else if (proceed && !last_row) begin
            row_reg <= row_reg + mg_pkg::ROW_W'(1);
        end
        if (proceed && emit_reg) begin
            out_value_reg <= new_sum;
            out_last_reg  <= last_row;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_last   = out_last_reg;

endmodule

`default_nettype wire

[hw/rtl/int8_matrix_gain.sv]
// int8_matrix_gain: signed int8 gain, scalar or matrix-vector, wrap-around arithmetic.
// Depends on mg_pkg; instantiates mg_cfg and mg_engine.
//
// Usage:
//   Samples enter on the s_ stream, one int8 per transfer. Results leave on the
//   m_ stream, one int8 per transfer, with m_tlast on the final result of a sample.
//   The cfg_ channel writes registers 0..4 (gain_a, gain_b, out_rows, in_rows,
//   scalar_mode); it is always ready, and the user must write it only while
//   the block is idle; the block itself does not enforce this.
//   Scalar mode: each sample gives gain(0,0)*sample, with no row memory access.
//   Matrix mode: samples arrive column-major; every row sum passes once through
//   the memory read state and the shared multiply-accumulate state. The last sample
//   of a column emits out_rows results, row 0 first, through the output register.
//   Reset clears the configuration to scalar mode with zero gain, the column
//   position to zero and the row sums to zero (by per-entry valid bits).
//   A stalled receiver holds the output register; a new sample is still taken
//   while a result waits, and the engine only waits once it has the next result.
`default_nettype none

module int8_matrix_gain (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Input stream; s_tdata[7:0] = sample.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,
    // Result stream; m_tdata[7:0] = value.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [7:0]                    m_tdata,
    output logic                               m_tlast,
    // Configuration write channel.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mg_pkg::CFG_DATA_W-1:0] cfg_data
);

    mg_pkg::cfg_t cfg;

    mg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mg_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_sample (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_value  (m_tdata),
        .m_last   (m_tlast)
    );

endmodule

`default_nettype wire

[hw/rtl/mg_checker.sv]
// Port-level checker for int8_matrix_gain, attached by the bind at the end of this file.
// Depends on int8_matrix_gain_macros.svh for the assertion macros.
`default_nettype none
`include "int8_matrix_gain_macros.svh"

module mg_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // No result is offered right after reset.
    `MG_ASSERT_NXT_ALWAYS(a_reset_quiet, aclk, !aresetn, !m_tvalid)

    // A stalled result holds its payload.
    `MG_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // One sample at a time: the block is busy in the cycle after an input transfer.
    `MG_ASSERT_NXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // While a non-final result of a column leaves, the rest of the column is still in work.
    `MG_ASSERT_IMP(a_busy_mid_column, aclk, aresetn, m_tvalid && m_tready && !m_tlast, !s_tready)

endmodule

bind int8_matrix_gain mg_checker u_mg_checker (.*);

`default_nettype wire
